// ===== rtl/depth_noise_backprojection_assert.svh =====
// Assertion macros for the depth noise back-projection RTL.
// Expects signals named clk and rst_n in the including scope.
`ifndef DEPTH_NOISE_BACKPROJECTION_ASSERT_SVH
`define DEPTH_NOISE_BACKPROJECTION_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define DNB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define DNB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dnb_pkg.sv =====
// Shared types and constants for the depth noise back-projection block.
// No dependencies; used by dnb_noise, dnb_proj and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dnb_pkg;

    // Field widths
    localparam int DEPTH_W         = 16;
    localparam int SAMPLE_W        = 16;
    localparam int INV_W           = 24;
    localparam int CENTER_W        = 16;
    localparam int GAIN_W          = 32;
    localparam int POINT_W         = 32;
    localparam int COORD_BITS_DEF  = 12;

    // Fixed-point scaling
    localparam int NOISE_FRAC_BITS = 44;
    localparam int PROJ_SHIFT      = 28;

    // Configuration port
    localparam int CFG_ADDR_W      = 5;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_IDX_W       = 3;

    // Pipeline stage numbers
    localparam int ST_SQUARE    = 0;
    localparam int ST_GAIN      = 1;
    localparam int ST_SAMPLE    = 2;
    localparam int ST_SUM       = 3;
    localparam int ST_DEPTH     = 4;
    localparam int ST_SCALE_Z   = 5;
    localparam int ST_SCALE_INV = 6;
    localparam int ST_OUT       = 7;
    localparam int NUM_STAGES   = 8;

    // Register map, index = byte address / 4
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_FX            = 3'd0,
        REG_INV_FY            = 3'd1,
        REG_CENTER_X          = 3'd2,
        REG_CENTER_Y          = 3'd3,
        REG_NOISE_GAIN        = 3'd4,
        REG_CLOUD_ENABLE      = 3'd5,
        REG_INTRINSICS_LOADED = 3'd6
    } cfg_reg_t;

    // Reset values
    localparam logic [INV_W-1:0]    INV_FX_RST     = 24'd27962;
    localparam logic [INV_W-1:0]    INV_FY_RST     = 24'd27962;
    localparam logic [CENTER_W-1:0] CENTER_X_RST   = 16'd5120;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST   = 16'd3840;
    localparam logic [GAIN_W-1:0]   NOISE_GAIN_RST = 32'd11453;
    localparam logic                CLOUD_EN_RST   = 1'b1;
    localparam logic                LOADED_RST     = 1'b0;

    // Depth result handed from the noise path to the projection path
    typedef struct packed {
        logic               point;
        logic [DEPTH_W-1:0] depth;
    } dnb_depth_t;

endpackage

`default_nettype wire

// ===== rtl/depth_noise_backprojection.sv =====
// Top level of the depth noise back-projection block: register port,
// pipeline control and output stage. Depends on dnb_pkg, dnb_noise, dnb_proj.
`timescale 1ns / 1ps
`default_nettype none
`include "depth_noise_backprojection_assert.svh"

// Adds depth-squared noise to one depth pixel per item and back-projects it
// to a 3D point in mm. The block is an 8-stage pipeline: one item enters
// every clock while the output side keeps result_ready high, and results
// leave in order. Each stage holds its own valid bit and fills whenever it
// is empty or the stage after it moves, so item_ready only drops when all 8
// stages hold items and the output item is not taken. The multiplier chain
// (d*d, times gain, times sample, then offset times Z, times 1/f) is spread
// over the stages. Items accepted while intrinsics_loaded is 0 are consumed
// and give no result. Registers sit at byte address 4*index and should be
// written only while no item is in flight.
module depth_noise_backprojection
    import dnb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // register port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [CFG_ADDR_W-1:0]      paddr,
    input  wire logic [CFG_DATA_W-1:0]      pwdata,
    output logic [CFG_DATA_W-1:0]           prdata,
    output logic                            pready,
    // input items
    input  wire logic                       item_valid,
    output logic                            item_ready,
    input  wire logic [DEPTH_W-1:0]         depth_mm,
    input  wire logic [COORD_BITS-1:0]      pixel_col,
    input  wire logic [COORD_BITS-1:0]      pixel_row,
    input  wire logic signed [SAMPLE_W-1:0] gauss_sample,
    // result items
    output logic                            result_valid,
    input  wire logic                       result_ready,
    output logic [DEPTH_W-1:0]              noisy_depth_mm,
    output logic                            point_valid,
    output logic signed [POINT_W-1:0]       point_x_mm,
    output logic signed [POINT_W-1:0]       point_y_mm,
    output logic [DEPTH_W-1:0]              point_z_mm
);

    // Configuration registers
    logic [INV_W-1:0]    inv_fx_reg;
    logic [INV_W-1:0]    inv_fy_reg;
    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;
    logic [GAIN_W-1:0]   noise_gain_reg;
    logic                cloud_enable_reg;
    logic                loaded_reg;
    logic                cfg_wr;
    cfg_reg_t            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_fx_reg       <= INV_FX_RST;
            inv_fy_reg       <= INV_FY_RST;
            center_x_reg     <= CENTER_X_RST;
            center_y_reg     <= CENTER_Y_RST;
            noise_gain_reg   <= NOISE_GAIN_RST;
            cloud_enable_reg <= CLOUD_EN_RST;
            loaded_reg       <= LOADED_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_INV_FX:            inv_fx_reg       <= pwdata[INV_W-1:0];
                REG_INV_FY:            inv_fy_reg       <= pwdata[INV_W-1:0];
                REG_CENTER_X:          center_x_reg     <= pwdata[CENTER_W-1:0];
                REG_CENTER_Y:          center_y_reg     <= pwdata[CENTER_W-1:0];
                REG_NOISE_GAIN:        noise_gain_reg   <= pwdata[GAIN_W-1:0];
                REG_CLOUD_ENABLE:      cloud_enable_reg <= pwdata[0];
                REG_INTRINSICS_LOADED: loaded_reg       <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (cfg_idx)
            REG_INV_FX:            prdata = CFG_DATA_W'(inv_fx_reg);
            REG_INV_FY:            prdata = CFG_DATA_W'(inv_fy_reg);
            REG_CENTER_X:          prdata = CFG_DATA_W'(center_x_reg);
            REG_CENTER_Y:          prdata = CFG_DATA_W'(center_y_reg);
            REG_NOISE_GAIN:        prdata = CFG_DATA_W'(noise_gain_reg);
            REG_CLOUD_ENABLE:      prdata = CFG_DATA_W'(cloud_enable_reg);
            REG_INTRINSICS_LOADED: prdata = CFG_DATA_W'(loaded_reg);
            default:               prdata = '0;
        endcase
    end

    // Stage advance: a stage loads when empty or when the next one moves
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] adv;

    always_comb
    begin
        adv[ST_OUT] = !valid_reg[ST_OUT] || result_ready;
        for (int k = ST_OUT - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign item_ready = adv[ST_SQUARE];

    always_comb
    begin
        valid_next = valid_reg;
        if (adv[ST_SQUARE])
        begin
            valid_next[ST_SQUARE] = item_valid && loaded_reg;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Noise path, stages 0 to 4
    dnb_depth_t depth_res;

    dnb_noise u_noise (
        .clk          (clk),
        .adv          (adv[ST_DEPTH:0]),
        .depth_mm     (depth_mm),
        .gauss_sample (gauss_sample),
        .noise_gain   (noise_gain_reg),
        .cloud_enable (cloud_enable_reg),
        .depth_res    (depth_res)
    );

    // Back-projection, one unit per axis
    dnb_proj #(.COORD_BITS(COORD_BITS)) u_proj_x (
        .clk       (clk),
        .adv       (adv),
        .pix       (pixel_col),
        .center    (center_x_reg),
        .inv       (inv_fx_reg),
        .depth_res (depth_res),
        .coord     (point_x_mm)
    );

    dnb_proj #(.COORD_BITS(COORD_BITS)) u_proj_y (
        .clk       (clk),
        .adv       (adv),
        .pix       (pixel_row),
        .center    (center_y_reg),
        .inv       (inv_fy_reg),
        .depth_res (depth_res),
        .coord     (point_y_mm)
    );

    // Carry depth and point flag alongside the projection stages
    dnb_depth_t         zd5_reg;
    dnb_depth_t         zd6_reg;
    dnb_depth_t         zd7_reg;
    logic [DEPTH_W-1:0] pz7_reg;

    always_ff @(posedge clk)
    begin
        if (adv[ST_SCALE_Z])
        begin
            zd5_reg <= depth_res;
        end
        if (adv[ST_SCALE_INV])
        begin
            zd6_reg <= zd5_reg;
        end
        if (adv[ST_OUT])
        begin
            zd7_reg <= zd6_reg;
            pz7_reg <= zd6_reg.point ? zd6_reg.depth : '0;
        end
    end

    assign result_valid   = valid_reg[ST_OUT];
    assign noisy_depth_mm = zd7_reg.depth;
    assign point_valid    = zd7_reg.point;
    assign point_z_mm     = pz7_reg;

    // Checks
    `DNB_ASSERT_NEXT(a_unloaded_drop, item_valid && item_ready && !loaded_reg,
        !valid_reg[ST_SQUARE], "item accepted without intrinsics entered the pipe")
    `DNB_ASSERT_SAME(a_full_when_blocked, !item_ready,
        &valid_reg, "input blocked while a pipeline stage is empty")
    `DNB_ASSERT_SAME(a_no_point_zero, result_valid && !point_valid,
        point_x_mm == '0 && point_y_mm == '0 && point_z_mm == '0,
        "point coordinates nonzero without a point")
    `DNB_ASSERT_SAME(a_point_z_depth, result_valid && point_valid,
        point_z_mm == noisy_depth_mm, "point Z differs from output depth")

endmodule

`default_nettype wire

// ===== rtl/dnb_noise.sv =====
// Depth noise path: squares depth, scales by gain and sample, applies the
// noise and saturates. Depends on dnb_pkg; stage enables come from the top.
`timescale 1ns / 1ps
`default_nettype none

module dnb_noise
    import dnb_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic [ST_DEPTH:0]          adv,
    input  wire logic [DEPTH_W-1:0]         depth_mm,
    input  wire logic signed [SAMPLE_W-1:0] gauss_sample,
    input  wire logic [GAIN_W-1:0]          noise_gain,
    input  wire logic                       cloud_enable,
    output dnb_depth_t                      depth_res
);

    localparam int DD_W  = 2 * DEPTH_W;
    localparam int P_W   = DD_W + GAIN_W;
    localparam int AB_W  = 32 + SAMPLE_W;
    localparam int N_W   = P_W + SAMPLE_W;
    localparam int Q_W   = N_W - NOISE_FRAC_BITS;
    localparam int SUM_W = Q_W + 1;

    // Stage 0: square depth, sample magnitude
    logic [DEPTH_W-1:0]  d_reg    [0:ST_SUM];
    logic                sneg_reg [0:ST_SUM];
    logic                pass_reg [0:ST_SUM];
    logic [SAMPLE_W-1:0] smag_reg [0:ST_GAIN];
    logic [DD_W-1:0]     dd0_reg;
    logic [SAMPLE_W-1:0] gs_u;
    logic [SAMPLE_W-1:0] smag_next;

    assign gs_u      = gauss_sample;
    assign smag_next = gs_u[SAMPLE_W-1] ? (~gs_u + SAMPLE_W'(1)) : gs_u;

    // Stage 0 capture, then depth, sign and pass flag carried to the depth stage
    always_ff @(posedge clk)
    begin
        if (adv[ST_SQUARE])
        begin
            d_reg[ST_SQUARE]    <= depth_mm;
            sneg_reg[ST_SQUARE] <= gs_u[SAMPLE_W-1];
            pass_reg[ST_SQUARE] <= (depth_mm <= DEPTH_W'(1));
            smag_reg[ST_SQUARE] <= smag_next;
            dd0_reg             <= DD_W'(depth_mm) * DD_W'(depth_mm);
        end
        for (int k = ST_GAIN; k <= ST_SUM; k++)
        begin
            if (adv[k])
            begin
                d_reg[k]    <= d_reg[k-1];
                sneg_reg[k] <= sneg_reg[k-1];
                pass_reg[k] <= pass_reg[k-1];
            end
        end
    end

    // Stage 1: d*d*gain
    logic [P_W-1:0] p1_reg;

    always_ff @(posedge clk)
    begin
        if (adv[ST_GAIN])
        begin
            p1_reg             <= P_W'(dd0_reg) * P_W'(noise_gain);
            smag_reg[ST_GAIN]  <= smag_reg[ST_SQUARE];
        end
    end

    // Stage 2: split product times sample magnitude
    logic [AB_W-1:0] a2_reg;
    logic [AB_W-1:0] b2_reg;

    always_ff @(posedge clk)
    begin
        if (adv[ST_SAMPLE])
        begin
            a2_reg <= AB_W'(p1_reg[31:0]) * AB_W'(smag_reg[ST_GAIN]);
            b2_reg <= AB_W'(p1_reg[P_W-1:32]) * AB_W'(smag_reg[ST_GAIN]);
        end
    end

    // Stage 3: recombine, take integer mm and sticky fraction
    logic [N_W-1:0] n_sum;
    logic [Q_W-1:0] q3_reg;
    logic           fnz3_reg;

    assign n_sum = {b2_reg, 32'b0} + N_W'(a2_reg);

    always_ff @(posedge clk)
    begin
        if (adv[ST_SUM])
        begin
            q3_reg   <= n_sum[N_W-1:NOISE_FRAC_BITS];
            fnz3_reg <= |n_sum[NOISE_FRAC_BITS-1:0];
        end
    end

    // Stage 4: apply noise, clamp, decide on point
    logic [SUM_W-1:0] up_sum;
    dnb_depth_t       depth_next;
    dnb_depth_t       depth4_reg;

    assign up_sum = SUM_W'(d_reg[ST_SUM]) + SUM_W'(q3_reg);

    always_comb
    begin
        depth_next = '0;
        priority if (pass_reg[ST_SUM])
        begin
            depth_next.depth = d_reg[ST_SUM];
            depth_next.point = 1'b0;
        end
        else if (!sneg_reg[ST_SUM])
        begin
            depth_next.depth = (|up_sum[SUM_W-1:DEPTH_W]) ? '1 : up_sum[DEPTH_W-1:0];
            depth_next.point = cloud_enable;
        end
        else if (q3_reg >= Q_W'(d_reg[ST_SUM]))
        begin
            depth_next.depth = '0;
            depth_next.point = 1'b0;
        end
        else
        begin
            depth_next.depth = d_reg[ST_SUM] - q3_reg[DEPTH_W-1:0]
                             - DEPTH_W'(fnz3_reg);
            depth_next.point = cloud_enable;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_DEPTH])
        begin
            depth4_reg <= depth_next;
        end
    end

    assign depth_res = depth4_reg;

endmodule

`default_nettype wire

// ===== rtl/dnb_proj.sv =====
// Pinhole back-projection of one axis: (pix*16 - center) * Z * inv >> 28,
// toward zero, saturated to 32 bits signed. Depends on dnb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dnb_proj
    import dnb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic [NUM_STAGES-1:0]  adv,
    input  wire logic [COORD_BITS-1:0]  pix,
    input  wire logic [CENTER_W-1:0]    center,
    input  wire logic [INV_W-1:0]       inv,
    input  wire dnb_depth_t             depth_res,
    output logic signed [POINT_W-1:0]   coord
);

    localparam int PIX_W = COORD_BITS + 4;
    localparam int MAG_W = (PIX_W > CENTER_W) ? PIX_W : CENTER_W;
    localparam int MZ_W  = MAG_W + DEPTH_W;
    localparam int PR_W  = MZ_W + INV_W;
    localparam int Q_W   = PR_W - PROJ_SHIFT;
    localparam int QX_W  = POINT_W + 1;
    localparam logic [QX_W-1:0] POS_LIM = QX_W'(33'h0_7FFF_FFFF);
    localparam logic [QX_W-1:0] NEG_LIM = QX_W'(33'h0_8000_0000);

    // Stage 0: signed offset from principal point as sign and magnitude
    logic [MAG_W:0]   p16;
    logic [MAG_W:0]   cext;
    logic             neg_next;
    logic [MAG_W-1:0] mag_next;
    logic [MAG_W-1:0] mag_reg [0:ST_DEPTH];
    logic             neg_reg [0:ST_SCALE_INV];

    assign p16      = (MAG_W+1)'({pix, 4'b0});
    assign cext     = (MAG_W+1)'(center);
    assign neg_next = p16 < cext;
    assign mag_next = neg_next ? MAG_W'(cext - p16) : MAG_W'(p16 - cext);

    // Magnitude carried to the depth stage, sign carried to the last multiply
    always_ff @(posedge clk)
    begin
        if (adv[ST_SQUARE])
        begin
            mag_reg[ST_SQUARE] <= mag_next;
            neg_reg[ST_SQUARE] <= neg_next;
        end
        for (int k = ST_GAIN; k <= ST_DEPTH; k++)
        begin
            if (adv[k])
            begin
                mag_reg[k] <= mag_reg[k-1];
            end
        end
        for (int k = ST_GAIN; k <= ST_SCALE_INV; k++)
        begin
            if (adv[k])
            begin
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    // Stage 5: offset times Z
    logic [MZ_W-1:0] mz5_reg;
    logic            pt_reg [ST_SCALE_Z:ST_SCALE_INV];

    always_ff @(posedge clk)
    begin
        if (adv[ST_SCALE_Z])
        begin
            mz5_reg             <= MZ_W'(mag_reg[ST_DEPTH]) * MZ_W'(depth_res.depth);
            pt_reg[ST_SCALE_Z]  <= depth_res.point;
        end
    end

    // Stage 6: times reciprocal focal length
    logic [PR_W-1:0] pr6_reg;

    always_ff @(posedge clk)
    begin
        if (adv[ST_SCALE_INV])
        begin
            pr6_reg               <= PR_W'(mz5_reg) * PR_W'(inv);
            pt_reg[ST_SCALE_INV]  <= pt_reg[ST_SCALE_Z];
        end
    end

    // Stage 7: drop fraction, saturate, apply sign
    logic [QX_W-1:0]    qx;
    logic [QX_W-1:0]    qn;
    logic [POINT_W-1:0] coord_next;
    logic [POINT_W-1:0] coord_reg;

    assign qx = QX_W'(pr6_reg[PROJ_SHIFT +: Q_W]);
    assign qn = (qx > NEG_LIM) ? NEG_LIM : qx;

    always_comb
    begin
        priority if (!pt_reg[ST_SCALE_INV])
        begin
            coord_next = '0;
        end
        else if (!neg_reg[ST_SCALE_INV])
        begin
            coord_next = (qx > POS_LIM) ? POS_LIM[POINT_W-1:0] : qx[POINT_W-1:0];
        end
        else
        begin
            coord_next = POINT_W'(0) - qn[POINT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_OUT])
        begin
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule

`default_nettype wire

// ===== dv/depth_noise_backprojection_checker.sv =====
// Checker for the depth noise back-projection block: tracks register writes,
// predicts each pixel result and compares delivered results in order.
// Depends on dnb_pkg.
`timescale 1ns / 1ps

module depth_noise_backprojection_checker
    import dnb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // register port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic                       pready,
    input  wire logic [CFG_ADDR_W-1:0]      paddr,
    input  wire logic [CFG_DATA_W-1:0]      pwdata,
    // pixel items
    input  wire logic                       item_valid,
    input  wire logic                       item_ready,
    input  wire logic [DEPTH_W-1:0]         depth_mm,
    input  wire logic [COORD_BITS-1:0]      pixel_col,
    input  wire logic [COORD_BITS-1:0]      pixel_row,
    input  wire logic signed [SAMPLE_W-1:0] gauss_sample,
    // result items
    input  wire logic                       result_valid,
    input  wire logic                       result_ready,
    input  wire logic [DEPTH_W-1:0]         noisy_depth_mm,
    input  wire logic                       point_valid,
    input  wire logic signed [POINT_W-1:0]  point_x_mm,
    input  wire logic signed [POINT_W-1:0]  point_y_mm,
    input  wire logic [DEPTH_W-1:0]         point_z_mm,
    // status for the testbench top
    output int                              mismatches,
    output int                              outstanding
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [DEPTH_W-1:0]        noisy_depth;
        logic                      has_point;
        logic signed [POINT_W-1:0] x_mm;
        logic signed [POINT_W-1:0] y_mm;
        logic [DEPTH_W-1:0]        z_mm;
    } pixel_result_t;

    // Shadow copy of the camera registers
    logic [INV_W-1:0]    inv_fx;
    logic [INV_W-1:0]    inv_fy;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [GAIN_W-1:0]   noise_gain;
    logic                cloud_enable;
    logic                intrinsics_loaded;

    pixel_result_t due_pixels[$];
    int            fail_total;
    int            reported;

    // Pinhole back-projection of one axis: (pix*16 - center) * z * inv >> 28,
    // toward zero, clamped to the signed 32-bit range
    function automatic logic [POINT_W-1:0] project_axis(
        input logic [COORD_BITS-1:0] pix,
        input logic [CENTER_W-1:0]   center,
        input logic [INV_W-1:0]      inv,
        input logic [DEPTH_W-1:0]    z
    );
        logic [31:0] pix16;
        logic [31:0] offset;
        logic        left;
        logic [63:0] scaled;
        pix16  = 32'(pix) << 4;
        left   = pix16 < 32'(center);
        offset = left ? 32'(center) - pix16 : pix16 - 32'(center);
        scaled = (64'(offset) * 64'(z) * 64'(inv)) >> PROJ_SHIFT;
        if (!left)
            return (scaled > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : scaled[31:0];
        if (scaled > 64'h8000_0000)
            scaled = 64'h8000_0000;
        return 32'(64'd0 - scaled);
    endfunction

    // Noisy depth and 3D point for one pixel under the current registers
    function automatic pixel_result_t noisy_pixel(
        input logic [DEPTH_W-1:0]         d,
        input logic [COORD_BITS-1:0]      col,
        input logic [COORD_BITS-1:0]      row,
        input logic signed [SAMPLE_W-1:0] sample
    );
        pixel_result_t        res;
        logic [SAMPLE_W-1:0]  s_bits;
        logic [SAMPLE_W:0]    s_mag;
        logic [63:0]          spread;
        logic [95:0]          noise;
        logic [63:0]          whole;
        logic                 has_frac;
        logic [63:0]          depth_wide;
        logic                 has_point;
        res       = '0;
        has_point = 1'b0;
        s_bits    = sample;
        s_mag     = s_bits[SAMPLE_W-1] ? 17'h10000 - {1'b0, s_bits} : {1'b0, s_bits};
        // |noise| = d*d*gain*|s|, scaled by 2^-44 mm
        spread    = 64'(d) * 64'(d) * 64'(noise_gain);
        noise     = 96'(spread) * 96'(s_mag);
        whole     = 64'(noise >> NOISE_FRAC_BITS);
        has_frac  = |noise[NOISE_FRAC_BITS-1:0];
        if (d <= 1)
        begin
            depth_wide = 64'(d);
        end
        else if (!s_bits[SAMPLE_W-1])
        begin
            depth_wide = 64'(d) + whole;
            if (depth_wide > 64'hFFFF)
                depth_wide = 64'hFFFF;
            has_point = 1'b1;
        end
        else if (whole >= 64'(d))
        begin
            depth_wide = 64'd0;
        end
        else
        begin
            // negative noise with a fraction rounds one more mm toward zero
            depth_wide = 64'(d) - whole - 64'(has_frac);
            has_point  = 1'b1;
        end
        res.noisy_depth = depth_wide[DEPTH_W-1:0];
        if (has_point && cloud_enable)
        begin
            res.has_point = 1'b1;
            res.x_mm      = project_axis(col, center_x, inv_fx, depth_wide[DEPTH_W-1:0]);
            res.y_mm      = project_axis(row, center_y, inv_fy, depth_wide[DEPTH_W-1:0]);
            res.z_mm      = depth_wide[DEPTH_W-1:0];
        end
        return res;
    endfunction

    task automatic report_failure(input string what, input pixel_result_t want,
                                  input pixel_result_t got);
        fail_total++;
        if (reported < REPORT_LIMIT)
        begin
            reported++;
            $display("%0t %s: expected depth=%0d pv=%0b x=%0d y=%0d z=%0d", $time, what,
                     want.noisy_depth, want.has_point, want.x_mm, want.y_mm, want.z_mm);
            $display("%0t %s: actual   depth=%0d pv=%0b x=%0d y=%0d z=%0d", $time, what,
                     got.noisy_depth, got.has_point, got.x_mm, got.y_mm, got.z_mm);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        pixel_result_t got;
        pixel_result_t want;
        if (!rst_n)
        begin
            inv_fx            = INV_FX_RST;
            inv_fy            = INV_FY_RST;
            center_x          = CENTER_X_RST;
            center_y          = CENTER_Y_RST;
            noise_gain        = NOISE_GAIN_RST;
            cloud_enable      = CLOUD_EN_RST;
            intrinsics_loaded = LOADED_RST;
            due_pixels.delete();
            fail_total        = 0;
            reported          = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // register writes; unmapped addresses are ignored
            if (psel && penable && pwrite && pready)
            begin
                unique case (paddr[CFG_ADDR_W-1:2])
                    REG_INV_FX:            inv_fx            = pwdata[INV_W-1:0];
                    REG_INV_FY:            inv_fy            = pwdata[INV_W-1:0];
                    REG_CENTER_X:          center_x          = pwdata[CENTER_W-1:0];
                    REG_CENTER_Y:          center_y          = pwdata[CENTER_W-1:0];
                    REG_NOISE_GAIN:        noise_gain        = pwdata[GAIN_W-1:0];
                    REG_CLOUD_ENABLE:      cloud_enable      = pwdata[0];
                    REG_INTRINSICS_LOADED: intrinsics_loaded = pwdata[0];
                    default: ;
                endcase
            end

            // accepted pixels: a result only while intrinsics are loaded
            if (item_valid && item_ready && intrinsics_loaded)
                due_pixels = {due_pixels, noisy_pixel(depth_mm, pixel_col, pixel_row,
                                                      gauss_sample)};

            // delivered results, in order
            if (result_valid && result_ready)
            begin
                got.noisy_depth = noisy_depth_mm;
                got.has_point   = point_valid;
                got.x_mm        = point_x_mm;
                got.y_mm        = point_y_mm;
                got.z_mm        = point_z_mm;
                if (due_pixels.size() == 0)
                begin
                    report_failure("unexpected result", '0, got);
                end
                else
                begin
                    want = due_pixels.pop_front();
                    if (got.noisy_depth !== want.noisy_depth || got.has_point !== want.has_point
                        || got.x_mm !== want.x_mm || got.y_mm !== want.y_mm
                        || got.z_mm !== want.z_mm)
                        report_failure("result mismatch", want, got);
                end
            end

            mismatches  <= fail_total;
            outstanding <= due_pixels.size();
        end
    end

endmodule

// ===== dv/tb_depth_noise_backprojection.sv =====
// Testbench top for depth_noise_backprojection: clock, reset, register
// writes, pixel stimulus and receiver stalls. Depends on dnb_pkg, the checker.
`timescale 1ns / 1ps

module tb_depth_noise_backprojection
    import dnb_pkg::*;
();

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 9;
    localparam int PIPE_SLACK   = 2 * NUM_STAGES;
    localparam int TIMEOUT_NS   = 3_000_000;
    localparam int NUM_PHASES   = 9;
    localparam int PHASE_ITEMS  = 55;
    localparam int IGNORED_ITEMS = 15;
    localparam int UNLOADED_PHASE = 5;

    // address past the end of the register map
    localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG = 3'd7;
    // 1.5 * 2^28: a 2 mm pixel with sample -4.0 loses 1.5 mm
    localparam logic [GAIN_W-1:0] TRUNC_GAIN = 32'd402653184;
    localparam logic [INV_W-1:0]  INV_MAX    = 24'hFF_FFFF;

    typedef enum logic [1:0] {RX_STREAM, RX_MOSTLY, RX_SPARSE, RX_PATTERN} rx_mode_t;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        psel         = 1'b0;
    logic                        penable      = 1'b0;
    logic                        pwrite       = 1'b0;
    logic [CFG_ADDR_W-1:0]       paddr        = '0;
    logic [CFG_DATA_W-1:0]       pwdata       = '0;
    logic [CFG_DATA_W-1:0]       prdata;
    logic                        pready;
    logic                        item_valid   = 1'b0;
    logic                        item_ready;
    logic [DEPTH_W-1:0]          depth_mm     = '0;
    logic [COORD_BITS_DEF-1:0]   pixel_col    = '0;
    logic [COORD_BITS_DEF-1:0]   pixel_row    = '0;
    logic signed [SAMPLE_W-1:0]  gauss_sample = '0;
    logic                        result_valid;
    logic                        result_ready = 1'b0;
    logic [DEPTH_W-1:0]          noisy_depth_mm;
    logic                        point_valid;
    logic signed [POINT_W-1:0]   point_x_mm;
    logic signed [POINT_W-1:0]   point_y_mm;
    logic [DEPTH_W-1:0]          point_z_mm;

    int mismatch_total;
    int results_due;
    int burst_left = 0;

    rx_mode_t   rx_mode    = RX_STREAM;
    int         rx_left    = 0;
    logic [7:0] rx_pattern = 8'b1011_0010;

    always #(CLK_PERIOD / 2) clk = ~clk;

    depth_noise_backprojection #(
        .COORD_BITS (COORD_BITS_DEF)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .depth_mm       (depth_mm),
        .pixel_col      (pixel_col),
        .pixel_row      (pixel_row),
        .gauss_sample   (gauss_sample),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .noisy_depth_mm (noisy_depth_mm),
        .point_valid    (point_valid),
        .point_x_mm     (point_x_mm),
        .point_y_mm     (point_y_mm),
        .point_z_mm     (point_z_mm)
    );

    depth_noise_backprojection_checker #(
        .COORD_BITS (COORD_BITS_DEF)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .depth_mm       (depth_mm),
        .pixel_col      (pixel_col),
        .pixel_row      (pixel_row),
        .gauss_sample   (gauss_sample),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .noisy_depth_mm (noisy_depth_mm),
        .point_valid    (point_valid),
        .point_x_mm     (point_x_mm),
        .point_y_mm     (point_y_mm),
        .point_z_mm     (point_z_mm),
        .mismatches     (mismatch_total),
        .outstanding    (results_due)
    );

    // Receiver: switches at random between stall modes
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 96);
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
        rx_pattern <= {rx_pattern[6:0], rx_pattern[7]};
        case (rx_mode)
            RX_STREAM: result_ready <= 1'b1;
            RX_MOSTLY: result_ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
            default:   result_ready <= rx_pattern[0];
        endcase
    end

    // Setup and access cycle; the caller releases the bus
    task automatic apb_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    // Writes every camera register, plus a junk write to an unmapped address
    task automatic set_camera(input logic [INV_W-1:0] fx, input logic [INV_W-1:0] fy,
                              input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy,
                              input logic [GAIN_W-1:0] gain, input logic cloud,
                              input logic loaded);
        apb_write(REG_INV_FX, 32'(fx));
        apb_write(REG_INV_FY, 32'(fy));
        apb_write(REG_CENTER_X, 32'(cx));
        apb_write(REG_CENTER_Y, 32'(cy));
        apb_write(REG_NOISE_GAIN, gain);
        apb_write(REG_CLOUD_ENABLE, {31'($urandom_range(0, 32'h7FFF_FFFF)), cloud});
        apb_write(REG_INTRINSICS_LOADED, {31'($urandom_range(0, 32'h7FFF_FFFF)), loaded});
        apb_write(UNMAPPED_REG, $urandom());
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // One pixel item, with burst/gap idling on the sender side
    task automatic push_pixel(input logic [DEPTH_W-1:0] d,
                              input logic [COORD_BITS_DEF-1:0] col,
                              input logic [COORD_BITS_DEF-1:0] row,
                              input logic signed [SAMPLE_W-1:0] s);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        item_valid   <= 1'b1;
        depth_mm     <= d;
        pixel_col    <= col;
        pixel_row    <= row;
        gauss_sample <= s;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    // Hold off until all results are in and the pipeline has flushed
    task automatic wait_for_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [INV_W-1:0]           fx;
        logic [INV_W-1:0]           fy;
        logic [CENTER_W-1:0]        cx;
        logic [CENTER_W-1:0]        cy;
        logic [GAIN_W-1:0]          gain;
        logic                       cloud;
        logic                       loaded;
        logic [DEPTH_W-1:0]         d;
        logic signed [SAMPLE_W-1:0] s;
        int                         n_items;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // intrinsics not loaded after reset: items are consumed silently
        push_pixel(16'd1000, 12'd10, 12'd20, 16'sd4096);
        push_pixel(16'd0, 12'd0, 12'd0, 16'sd0);
        push_pixel(16'hFFFF, 12'hFFF, 12'hFFF, -16'sd32768);
        wait_for_results();

        // depth pass-through, truncation, non-positive and overflow cases
        set_camera(INV_FX_RST, INV_FY_RST, CENTER_X_RST, CENTER_Y_RST, TRUNC_GAIN,
                   1'b1, 1'b1);
        push_pixel(16'd0, 12'd0, 12'd0, 16'sd0);
        push_pixel(16'd1, 12'hFFF, 12'hFFF, 16'sd32767);
        push_pixel(16'd1, 12'd5, 12'd7, -16'sd32768);
        push_pixel(16'd2, 12'd100, 12'd200, -16'sd16384);
        push_pixel(16'd2, 12'd100, 12'd200, -16'sd32768);
        push_pixel(16'd2, 12'd640, 12'd480, 16'sd0);
        push_pixel(16'hFFFF, 12'hFFF, 12'd0, 16'sd32767);
        push_pixel(16'hFFFF, 12'd0, 12'hFFF, -16'sd32768);
        push_pixel(16'd3, 12'd0, 12'd0, 16'sd1);
        push_pixel(16'd2, 12'hFFF, 12'hFFF, 16'sd16384);
        push_pixel(16'd40000, 12'd320, 12'd240, -16'sd1);
        wait_for_results();

        // points disabled
        set_camera(INV_FX_RST, INV_FY_RST, CENTER_X_RST, CENTER_Y_RST, TRUNC_GAIN,
                   1'b0, 1'b1);
        push_pixel(16'd500, 12'd10, 12'd10, 16'sd4096);
        push_pixel(16'd2, 12'd10, 12'd10, -16'sd16384);
        push_pixel(16'hFFFF, 12'd10, 12'd10, 16'sd32767);
        wait_for_results();

        // largest back-projection magnitudes
        set_camera(INV_MAX, INV_MAX, 16'hFFFF, 16'hFFFF, 32'd0, 1'b1, 1'b1);
        push_pixel(16'hFFFF, 12'd0, 12'd0, 16'sd0);
        push_pixel(16'hFFFF, 12'hFFF, 12'hFFF, 16'sd0);

        // random phases, each under its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_for_results();
            fx      = ($urandom_range(0, 3) != 0) ? 24'($urandom_range(11000, 60000))
                                                 : 24'($urandom());
            fy      = ($urandom_range(0, 3) != 0) ? 24'($urandom_range(11000, 60000))
                                                 : 24'($urandom());
            cx      = $urandom_range(0, 1) ? 16'(16 * $urandom_range(100, 3000))
                                           : 16'($urandom());
            cy      = $urandom_range(0, 1) ? 16'(16 * $urandom_range(100, 3000))
                                           : 16'($urandom());
            case ($urandom_range(0, 3))
                0:       gain = $urandom_range(2000, 40000);
                1:       gain = $urandom_range(0, 2000);
                2:       gain = $urandom_range(0, 32'h00FF_FFFF);
                default: gain = $urandom();
            endcase
            cloud   = ($urandom_range(0, 4) != 0);
            loaded  = 1'b1;
            n_items = PHASE_ITEMS;
            case (ph)
                0:
                begin
                    fx = INV_MAX; fy = INV_MAX; cx = '0; cy = '0;
                    gain = 32'hFFFF_FFFF; cloud = 1'b1;
                end
                1:
                begin
                    fx = '0; fy = '0; cx = 16'hFFFF; cy = 16'hFFFF;
                    gain = '0; cloud = 1'b1;
                end
                2:              cloud = 1'b0;
                UNLOADED_PHASE:
                begin
                    loaded  = 1'b0;
                    n_items = IGNORED_ITEMS;
                end
                default: ;
            endcase
            set_camera(fx, fy, cx, cy, gain, cloud, loaded);

            for (int k = 0; k < n_items; k++)
            begin
                case ($urandom_range(0, 9))
                    0:       d = 16'($urandom_range(0, 1));
                    1:       d = 16'($urandom_range(2, 8));
                    2:       d = 16'($urandom_range(60000, 65535));
                    3:       d = 16'($urandom());
                    default: d = 16'($urandom_range(200, 10000));
                endcase
                if ($urandom_range(0, 9) < 7)
                    s = 16'($urandom_range(0, 24576) - 12288);
                else
                    s = 16'($urandom());
                push_pixel(d, 12'($urandom()), 12'($urandom()), s);
                // let the pipeline run dry mid-phase now and then
                if ((ph == 3 && k == PHASE_ITEMS / 2) || $urandom_range(0, 99) == 0)
                    wait_for_results();
            end
        end

        wait_for_results();
        if (mismatch_total == 0 && results_due == 0)
            $display("** depth_noise_backprojection: PASSED **");
        else
            $display("** depth_noise_backprojection: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("** depth_noise_backprojection: FAILED **");
        $finish;
    end

endmodule

// ===== depth_noise_backprojection.f =====
+incdir+rtl
rtl/dnb_pkg.sv
rtl/dnb_noise.sv
rtl/dnb_proj.sv
rtl/depth_noise_backprojection.sv
dv/depth_noise_backprojection_checker.sv
dv/tb_depth_noise_backprojection.sv
